@@ hw/rtl/vau_pkg.sv @@
// Package for the three-component vector unit: widths, op codes, item types
// and the shared clamp and truncation helpers. No dependencies.
package vau_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int WIDE_W      = PROD_W + 2;
    localparam int RAD_W       = PROD_W;
    localparam int ROOT_W      = DATA_W;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int QUO_W       = FRAC_W + 1;
    localparam int DIV_STAGES  = QUO_W;
    localparam int S_DATA_W    = 232;
    localparam int M_DATA_W    = 136;

    localparam logic [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] NEG_MAX = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_SUB    = 3'd1,
        OP_SCALE  = 3'd2,
        OP_DOT    = 3'd3,
        OP_CROSS  = 3'd4,
        OP_MAG    = 3'd5,
        OP_NORM   = 3'd6,
        OP_EQUALS = 3'd7
    } op_t;

    typedef struct packed {
        op_t                   op;
        logic [2:0][DATA_W-1:0] a;
        logic [2:0][DATA_W-1:0] b;
        logic [DATA_W-1:0]      sf;
    } vau_in_t;

    typedef struct packed {
        op_t                    op;
        logic [2:0]             a_neg;
        logic [2:0][DATA_W-1:0] a_abs;
        logic [2:0][DATA_W-1:0] res;
        logic [DATA_W-1:0]      scalar;
        logic                   eq;
        logic                   sat;
    } vau_item_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              sat;
    } vau_sat_t;

    function automatic vau_sat_t vau_clamp(input logic [WIDE_W-1:0] v);
        vau_sat_t r;
        logic     fits;
        fits = (&v[WIDE_W-1:DATA_W-1]) || !(|v[WIDE_W-1:DATA_W-1]);
        r.sat = !fits;
        if (fits) begin
            r.value = v[DATA_W-1:0];
        end else if (v[WIDE_W-1]) begin
            r.value = NEG_MAX;
        end else begin
            r.value = POS_MAX;
        end
        return r;
    endfunction

    // shift out the fraction, rounding toward zero
    function automatic logic [WIDE_W-1:0] vau_trunc(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] t;
        t = v + (v[WIDE_W-1] ? WIDE_W'({FRAC_W{1'b1}}) : '0);
        return {{FRAC_W{t[WIDE_W-1]}}, t[WIDE_W-1:FRAC_W]};
    endfunction

endpackage

@@ hw/rtl/vau_front.sv @@
// Front stages of the vector unit: operand select, products, sums, rounding.
// Depends on vau_pkg.
module vau_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  vau_pkg::vau_in_t                 in_word,
    output logic                             out_valid,
    input  logic                             out_ready,
    output vau_pkg::vau_item_t               out_item,
    output logic [vau_pkg::RAD_W-1:0]        out_rad
);

    logic en1, en2, en3, en4;

    logic                                 s1_vld_reg;
    vau_pkg::vau_in_t                     s1_in_reg;
    logic [5:0][vau_pkg::DATA_W-1:0]      s1_ml_reg, s1_mr_reg;
    logic [5:0][vau_pkg::DATA_W-1:0]      s1_ml_next, s1_mr_next;

    logic                                 s2_vld_reg;
    vau_pkg::vau_item_t                   s2_item_reg, s2_item_next;
    logic [5:0][vau_pkg::PROD_W-1:0]      s2_prod_reg, s2_prod_next;

    logic                                 s3_vld_reg;
    vau_pkg::vau_item_t                   s3_item_reg;
    logic [2:0][vau_pkg::WIDE_W-1:0]      s3_w_reg, s3_w_next;

    logic                                 s4_vld_reg;
    vau_pkg::vau_item_t                   s4_item_reg, s4_item_next;
    logic [vau_pkg::RAD_W-1:0]            s4_rad_reg;

    assign en4      = !s4_vld_reg || out_ready;
    assign en3      = !s3_vld_reg || en4;
    assign en2      = !s2_vld_reg || en3;
    assign en1      = !s1_vld_reg || en2;
    assign in_ready = en1;

    always_comb begin
        s1_ml_next = '0;
        s1_mr_next = '0;
        unique case (in_word.op)
            vau_pkg::OP_SCALE: begin
                for (int i = 0; i < 3; i++) begin
                    s1_ml_next[i] = in_word.a[i];
                    s1_mr_next[i] = in_word.sf;
                end
            end
            vau_pkg::OP_DOT: begin
                for (int i = 0; i < 3; i++) begin
                    s1_ml_next[i] = in_word.a[i];
                    s1_mr_next[i] = in_word.b[i];
                end
            end
            vau_pkg::OP_CROSS: begin
                s1_ml_next[0] = in_word.a[1]; s1_mr_next[0] = in_word.b[2];
                s1_ml_next[3] = in_word.a[2]; s1_mr_next[3] = in_word.b[1];
                s1_ml_next[1] = in_word.a[2]; s1_mr_next[1] = in_word.b[0];
                s1_ml_next[4] = in_word.a[0]; s1_mr_next[4] = in_word.b[2];
                s1_ml_next[2] = in_word.a[0]; s1_mr_next[2] = in_word.b[1];
                s1_ml_next[5] = in_word.a[1]; s1_mr_next[5] = in_word.b[0];
            end
            vau_pkg::OP_MAG, vau_pkg::OP_NORM: begin
                for (int i = 0; i < 3; i++) begin
                    s1_ml_next[i] = in_word.a[i];
                    s1_mr_next[i] = in_word.a[i];
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        logic signed [vau_pkg::DATA_W-1:0] l, r;
        logic signed [vau_pkg::PROD_W-1:0] p;
        logic [vau_pkg::WIDE_W-1:0]        sa, sb, sum;
        vau_pkg::vau_sat_t                 c;
        s2_item_next        = '0;
        s2_item_next.op     = s1_in_reg.op;
        for (int i = 0; i < 6; i++) begin
            l = s1_ml_reg[i];
            r = s1_mr_reg[i];
            p = l * r;
            s2_prod_next[i] = p;
        end
        for (int i = 0; i < 3; i++) begin
            s2_item_next.a_neg[i] = s1_in_reg.a[i][vau_pkg::DATA_W-1];
            s2_item_next.a_abs[i] = s1_in_reg.a[i][vau_pkg::DATA_W-1] ?
                                    (~s1_in_reg.a[i] + 1'b1) : s1_in_reg.a[i];
            sa = {{(vau_pkg::WIDE_W-vau_pkg::DATA_W){s1_in_reg.a[i][vau_pkg::DATA_W-1]}},
                  s1_in_reg.a[i]};
            sb = {{(vau_pkg::WIDE_W-vau_pkg::DATA_W){s1_in_reg.b[i][vau_pkg::DATA_W-1]}},
                  s1_in_reg.b[i]};
            sum = (s1_in_reg.op == vau_pkg::OP_SUB) ? (sa - sb) : (sa + sb);
            c = vau_pkg::vau_clamp(sum);
            if (s1_in_reg.op == vau_pkg::OP_ADD || s1_in_reg.op == vau_pkg::OP_SUB) begin
                s2_item_next.res[i] = c.value;
                s2_item_next.sat    = s2_item_next.sat | c.sat;
            end
        end
        s2_item_next.eq = (s1_in_reg.op == vau_pkg::OP_EQUALS) &&
                          (s1_in_reg.a == s1_in_reg.b);
    end

    always_comb begin
        logic [5:0][vau_pkg::WIDE_W-1:0] e;
        logic [vau_pkg::WIDE_W-1:0]      sum3;
        for (int i = 0; i < 6; i++) begin
            e[i] = {{(vau_pkg::WIDE_W-vau_pkg::PROD_W){s2_prod_reg[i][vau_pkg::PROD_W-1]}},
                    s2_prod_reg[i]};
        end
        sum3     = e[0] + e[1] + e[2];
        s3_w_next = '0;
        unique case (s2_item_reg.op)
            vau_pkg::OP_SCALE: begin
                for (int i = 0; i < 3; i++) s3_w_next[i] = e[i];
            end
            vau_pkg::OP_CROSS: begin
                for (int i = 0; i < 3; i++) s3_w_next[i] = e[i] - e[i+3];
            end
            vau_pkg::OP_DOT, vau_pkg::OP_MAG, vau_pkg::OP_NORM: begin
                s3_w_next[0] = sum3;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        vau_pkg::vau_sat_t c;
        c            = '0;
        s4_item_next = s3_item_reg;
        unique case (s3_item_reg.op)
            vau_pkg::OP_SCALE, vau_pkg::OP_CROSS: begin
                for (int i = 0; i < 3; i++) begin
                    c = vau_pkg::vau_clamp(vau_pkg::vau_trunc(s3_w_reg[i]));
                    s4_item_next.res[i] = c.value;
                    s4_item_next.sat    = s4_item_next.sat | c.sat;
                end
            end
            vau_pkg::OP_DOT: begin
                c = vau_pkg::vau_clamp(vau_pkg::vau_trunc(s3_w_reg[0]));
                s4_item_next.scalar = c.value;
                s4_item_next.sat    = c.sat;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end else begin
            if (en1) s1_vld_reg <= in_valid;
            if (en2) s2_vld_reg <= s1_vld_reg;
            if (en3) s3_vld_reg <= s2_vld_reg;
            if (en4) s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            s1_in_reg <= in_word;
            s1_ml_reg <= s1_ml_next;
            s1_mr_reg <= s1_mr_next;
        end
        if (en2) begin
            s2_item_reg <= s2_item_next;
            s2_prod_reg <= s2_prod_next;
        end
        if (en3) begin
            s3_item_reg <= s2_item_reg;
            s3_w_reg    <= s3_w_next;
        end
        if (en4) begin
            s4_item_reg <= s4_item_next;
            s4_rad_reg  <= s3_w_reg[0][vau_pkg::RAD_W-1:0];
        end
    end

    assign out_valid = s4_vld_reg;
    assign out_item  = s4_item_reg;
    assign out_rad   = s4_rad_reg;

endmodule

@@ hw/rtl/vau_sqrt.sv @@
// Pipelined integer square root, one root bit per stage, item carried alongside.
// Depends on vau_pkg.
module vau_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  vau_pkg::vau_item_t            in_item,
    input  logic [vau_pkg::RAD_W-1:0]     in_rad,
    output logic                          out_valid,
    input  logic                          out_ready,
    output vau_pkg::vau_item_t            out_item,
    output logic [vau_pkg::ROOT_W-1:0]    out_root
);

    localparam int N = vau_pkg::SQRT_STAGES;

    logic                          vld_reg  [N];
    vau_pkg::vau_item_t            item_reg [N];
    logic [vau_pkg::RAD_W-1:0]     num_reg  [N];
    logic [vau_pkg::RAD_W-1:0]     res_reg  [N];
    logic [vau_pkg::RAD_W-1:0]     num_next [N];
    logic [vau_pkg::RAD_W-1:0]     res_next [N];
    logic [N:0]                    en;

    always_comb begin
        en[N] = out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        logic [vau_pkg::RAD_W-1:0] num_in, res_in, bit_k, trial;
        for (int k = 0; k < N; k++) begin
            num_in = (k == 0) ? in_rad : num_reg[(k == 0) ? 0 : k - 1];
            res_in = (k == 0) ? '0     : res_reg[(k == 0) ? 0 : k - 1];
            bit_k  = vau_pkg::RAD_W'(1) << (vau_pkg::RAD_W - 2 - 2 * k);
            trial  = res_in | bit_k;
            if (num_in >= trial) begin
                num_next[k] = num_in - trial;
                res_next[k] = (res_in >> 1) | bit_k;
            end else begin
                num_next[k] = num_in;
                res_next[k] = res_in >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) vld_reg[k] <= 1'b0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (en[k]) vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            if (en[k]) begin
                item_reg[k] <= (k == 0) ? in_item : item_reg[(k == 0) ? 0 : k - 1];
                num_reg[k]  <= num_next[k];
                res_reg[k]  <= res_next[k];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[N-1];
    assign out_item  = item_reg[N-1];
    assign out_root  = res_reg[N-1][vau_pkg::ROOT_W-1:0];

endmodule

@@ hw/rtl/vau_div.sv @@
// Pipelined restoring divider: three component quotients over the root,
// one quotient bit per stage. Depends on vau_pkg.
module vau_div (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  vau_pkg::vau_item_t                    in_item,
    input  logic [vau_pkg::ROOT_W-1:0]            in_root,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output vau_pkg::vau_item_t                    out_item,
    output logic [vau_pkg::ROOT_W-1:0]            out_root,
    output logic [2:0][vau_pkg::QUO_W-1:0]        out_quo
);

    localparam int N = vau_pkg::DIV_STAGES;

    logic                                 vld_reg  [N];
    vau_pkg::vau_item_t                   item_reg [N];
    logic [vau_pkg::ROOT_W-1:0]           root_reg [N];
    logic [2:0][vau_pkg::ROOT_W-1:0]      rem_reg  [N];
    logic [2:0][vau_pkg::QUO_W-1:0]       quo_reg  [N];
    logic [2:0][vau_pkg::ROOT_W-1:0]      rem_next [N];
    logic [2:0][vau_pkg::QUO_W-1:0]       quo_next [N];
    logic [N:0]                           en;

    always_comb begin
        en[N] = out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_comb begin
        logic [vau_pkg::ROOT_W-1:0] rem_in, root_in;
        logic [vau_pkg::QUO_W-1:0]  quo_in;
        logic [vau_pkg::ROOT_W:0]   sh, d;
        logic                       fb;
        for (int k = 0; k < N; k++) begin
            root_in = (k == 0) ? in_root : root_reg[(k == 0) ? 0 : k - 1];
            d       = {1'b0, root_in};
            for (int i = 0; i < 3; i++) begin
                if (k == 0) begin
                    rem_in = in_item.a_abs[i] >> 1;
                    quo_in = '0;
                    fb     = in_item.a_abs[i][0];
                end else begin
                    rem_in = rem_reg[(k == 0) ? 0 : k - 1][i];
                    quo_in = quo_reg[(k == 0) ? 0 : k - 1][i];
                    fb     = 1'b0;
                end
                sh = {rem_in, fb};
                if (sh >= d) begin
                    sh             = sh - d;
                    quo_next[k][i] = {quo_in[vau_pkg::QUO_W-2:0], 1'b1};
                end else begin
                    quo_next[k][i] = {quo_in[vau_pkg::QUO_W-2:0], 1'b0};
                end
                rem_next[k][i] = sh[vau_pkg::ROOT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < N; k++) vld_reg[k] <= 1'b0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (en[k]) vld_reg[k] <= (k == 0) ? in_valid : vld_reg[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < N; k++) begin
            if (en[k]) begin
                item_reg[k] <= (k == 0) ? in_item : item_reg[(k == 0) ? 0 : k - 1];
                root_reg[k] <= (k == 0) ? in_root : root_reg[(k == 0) ? 0 : k - 1];
                rem_reg[k]  <= rem_next[k];
                quo_reg[k]  <= quo_next[k];
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[N-1];
    assign out_item  = item_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_quo   = quo_reg[N-1];

endmodule

@@ hw/rtl/vector3_arithmetic_unit.sv @@
// Pipeline from input word to result word: 4 front stages, 32 root stages,
//   17 divide stages, 1 output register.
// Throughput: one word per cycle for every op unless m_tready stalls the output;
//   set by the one-bit-per-stage root and divide pipelines, each stage holding one word.
// Reset: aresetn low clears all stage valid bits; payload is not reset.
// Top level of the vector unit; depends on vau_pkg, vau_front, vau_sqrt, vau_div.
module vector3_arithmetic_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // op, a_x, a_y, a_z, b_x, b_y, b_z, scale_factor, zero pad
    input  logic [vau_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // res_x, res_y, res_z, scalar_result, is_equal, zero_length_error, saturated, pad
    output logic [vau_pkg::M_DATA_W-1:0]      m_tdata
);

    vau_pkg::vau_in_t                     in_word;
    vau_pkg::vau_item_t                   fr_item, sq_item, dv_item;
    logic [vau_pkg::RAD_W-1:0]            fr_rad;
    logic [vau_pkg::ROOT_W-1:0]           sq_root, dv_root;
    logic [2:0][vau_pkg::QUO_W-1:0]       dv_quo;
    logic                                 fr_valid, fr_ready, sq_valid, sq_ready;
    logic                                 dv_valid, dv_ready;

    logic                                 out_vld_reg;
    logic [2:0][vau_pkg::DATA_W-1:0]      res_reg, res_next;
    logic [vau_pkg::DATA_W-1:0]           scalar_reg, scalar_next;
    logic                                 eq_reg, err_reg, err_next, sat_reg, sat_next;
    logic                                 out_en;

    assign in_word.op   = vau_pkg::op_t'(s_tdata[2:0]);
    assign in_word.a[0] = s_tdata[34:3];
    assign in_word.a[1] = s_tdata[66:35];
    assign in_word.a[2] = s_tdata[98:67];
    assign in_word.b[0] = s_tdata[130:99];
    assign in_word.b[1] = s_tdata[162:131];
    assign in_word.b[2] = s_tdata[194:163];
    assign in_word.sf   = s_tdata[226:195];

    vau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (in_word),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item),
        .out_rad   (fr_rad)
    );

    vau_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .in_rad    (fr_rad),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .out_item  (sq_item),
        .out_root  (sq_root)
    );

    vau_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .in_item   (sq_item),
        .in_root   (sq_root),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_item  (dv_item),
        .out_root  (dv_root),
        .out_quo   (dv_quo)
    );

    assign out_en   = !out_vld_reg || m_tready;
    assign dv_ready = out_en;

    always_comb begin
        logic [vau_pkg::DATA_W-1:0] q;
        q           = '0;
        res_next    = dv_item.res;
        scalar_next = dv_item.scalar;
        sat_next    = dv_item.sat;
        err_next    = 1'b0;
        unique case (dv_item.op)
            vau_pkg::OP_MAG: begin
                if (dv_root[vau_pkg::ROOT_W-1]) begin
                    scalar_next = vau_pkg::POS_MAX;
                    sat_next    = 1'b1;
                end else begin
                    scalar_next = dv_root;
                end
            end
            vau_pkg::OP_NORM: begin
                if (dv_root == '0) begin
                    err_next = 1'b1;
                    res_next = '0;
                end else begin
                    for (int i = 0; i < 3; i++) begin
                        q = vau_pkg::DATA_W'(dv_quo[i]);
                        res_next[i] = dv_item.a_neg[i] ? (~q + 1'b1) : q;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_en) begin
            out_vld_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) begin
            res_reg    <= res_next;
            scalar_reg <= scalar_next;
            eq_reg     <= dv_item.eq;
            err_reg    <= err_next;
            sat_reg    <= sat_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'b0, sat_reg, err_reg, eq_reg, scalar_reg,
                       res_reg[2], res_reg[1], res_reg[0]};

endmodule

@@ hw/rtl/vau_checker.sv @@
// Port-level checks for the vector unit, bound to the top level.
// Depends on vau_pkg and vector3_arithmetic_unit.
module vau_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [vau_pkg::S_DATA_W-1:0]   s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [vau_pkg::M_DATA_W-1:0]   m_tdata
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input word changed while waiting");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_zero_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[129] |-> m_tdata[127:0] == '0 && !m_tdata[128] && !m_tdata[130])
        else $error("zero length word carries data");

    a_equal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[128] |-> m_tdata[127:0] == '0 && !m_tdata[130])
        else $error("equality word carries data");

endmodule

bind vector3_arithmetic_unit vau_checker u_vau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
